### rtl/pcicfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI endpoint responder package
// Shared constants, decode word type and the config header reset image.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

   localparam int unsigned CFG_BYTES  = 4096;
   localparam int unsigned WIN_BYTES  = 65536;
   localparam int unsigned LANES      = 8;
   localparam int unsigned CFG_ROWS   = CFG_BYTES / LANES;
   localparam int unsigned WIN_ROWS   = WIN_BYTES / LANES;
   localparam int unsigned CFG_ADDR_W = $clog2(CFG_BYTES);
   localparam int unsigned WIN_ADDR_W = $clog2(WIN_BYTES);
   localparam int unsigned CFG_ROW_W  = CFG_ADDR_W - 3;
   localparam int unsigned WIN_ROW_W  = WIN_ADDR_W - 3;

   localparam int unsigned BAR0_OFFSET    = 'h10;
   localparam int unsigned BAR0_ROW       = BAR0_OFFSET / LANES;
   localparam logic [31:0] BAR0_KEEP_MASK = ~(32'(WIN_BYTES - 1)) & 32'hFFFF_FFF0;
   localparam logic [31:0] BAR0_FLAGS     = 32'h0000_0004;
   localparam logic [3:0]  BAR0_SIZE      = 4'd4;
   localparam logic [3:0]  CFG_MAX_BYTES  = 4'd4;
   localparam logic [3:0]  WIN_MAX_BYTES  = 4'd8;
   localparam logic [63:0] BAR0_RESET     = 64'h0000_0000_0000_0004;

   localparam logic OP_READ   = 1'b0;
   localparam logic OP_WRITE  = 1'b1;
   localparam logic SPACE_CFG = 1'b0;
   localparam logic SPACE_MEM = 1'b1;

   typedef struct packed {
      logic                 hit;
      logic [2:0]           lane;
      logic [7:0]           be;
      logic [CFG_ROW_W-1:0] cfg_row;
      logic [WIN_ROW_W-1:0] win_row;
      logic [7:0][7:0]      wbytes;
   } dec_type;

   function automatic logic [7:0] cfg_reset_byte(input logic [CFG_ADDR_W-1:0] off);
      logic [7:0] b;
      b = 8'h00;
      if (off >= CFG_ADDR_W'('h44)) begin
         b = 8'hFF;
      end else begin
         case (off[6:0])
            7'h00: b = 8'h86;
            7'h01: b = 8'h80;
            7'h02: b = 8'h34;
            7'h03: b = 8'h12;
            7'h04: b = 8'h06;
            7'h06: b = 8'h10;
            7'h08: b = 8'h01;
            7'h09: b = 8'h10;
            7'h0A: b = 8'h02;
            7'h0B: b = 8'h05;
            7'h10: b = 8'h04;
            7'h2C: b = 8'h86;
            7'h2D: b = 8'h80;
            7'h2E: b = 8'h34;
            7'h2F: b = 8'h12;
            7'h34: b = 8'h40;
            7'h40: b = 8'h10;
            7'h42: b = 8'h02;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

### rtl/pci_endpoint_cfg_mmio_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI type-0 endpoint config space and BAR0 window responder
// Answers each config or memory transaction with its tag and read data.
// ----------------------------------------------------------------------------
// One transaction is taken at each clock edge where start is high and busy is
// low, and its reply appears on the rsp_ ports in the next cycle, strobed by
// rsp_strobe for exactly one cycle; the receiver cannot stall it. A new
// transaction may start in every cycle while busy is low, so the sustained
// rate is one item per clock. Config space and the window each live in eight
// byte-wide banks, so any access of up to eight bytes touches each bank at
// most once and all its bytes are handled together; a write is seen by a read
// in the very next cycle. After reset, busy stays high while the header image
// is loaded into config space, one eight-byte row per cycle. Window bytes that
// were never written read back as undefined data.
// ----------------------------------------------------------------------------
module pci_endpoint_cfg_mmio_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic        req_space,
   input  logic [4:0]  req_device_number,
   input  logic [2:0]  req_function_number,
   input  logic [63:0] req_address,
   input  logic [3:0]  req_byte_count,
   input  logic [63:0] req_write_data,
   input  logic [31:0] req_tag,
   output logic        rsp_strobe,
   output logic [31:0] rsp_reply_tag,
   output logic [63:0] rsp_read_data
);

   localparam int unsigned L = pcicfg_pkg::LANES;

   logic [7:0] cfg_mem [L][pcicfg_pkg::CFG_ROWS];
   logic [7:0] win_mem [L][pcicfg_pkg::WIN_ROWS];

   pcicfg_pkg::dec_type              dec;
   logic                             accept;
   logic                             cfg_wr;
   logic                             win_wr;
   logic [pcicfg_pkg::CFG_ROW_W-1:0] cfg_addr [L];
   logic [pcicfg_pkg::WIN_ROW_W-1:0] win_addr [L];
   logic [7:0]                       cfg_wbyte [L];
   logic [L-1:0]                     cfg_we;
   logic [L-1:0]                     win_we;
   logic [2:0]                       rsrc [L];

   logic                             clear_active_ff, clear_active_in;
   logic [pcicfg_pkg::CFG_ROW_W-1:0] clear_row_ff, clear_row_in;
   logic [63:0]                      bar_ff, bar_in;
   logic                             strobe_ff;
   logic [7:0][7:0]                  cfg_rdata_ff;
   logic [7:0][7:0]                  win_rdata_ff;
   logic [31:0]                      tag_ff;
   logic                             op_ff;
   logic                             space_ff;
   logic                             hit_ff;
   logic [2:0]                       lane_ff;
   logic [3:0]                       count_ff;

   pcicfg_decode u_decode (
      .req_op              (req_op),
      .req_space           (req_space),
      .req_device_number   (req_device_number),
      .req_function_number (req_function_number),
      .req_address         (req_address),
      .req_byte_count      (req_byte_count),
      .req_write_data      (req_write_data),
      .bar_base            (bar_ff),
      .dec                 (dec)
   );

   assign busy   = clear_active_ff;
   assign accept = start & ~clear_active_ff;
   assign cfg_wr = accept & (req_op == pcicfg_pkg::OP_WRITE)
                 & (req_space == pcicfg_pkg::SPACE_CFG) & dec.hit;
   assign win_wr = accept & (req_op == pcicfg_pkg::OP_WRITE)
                 & (req_space == pcicfg_pkg::SPACE_MEM) & dec.hit;

   // steer bank rows: banks below the start lane take the next row
   always_comb begin
      for (int b = 0; b < L; b++) begin
         if (clear_active_ff) begin
            cfg_addr[b]  = clear_row_ff;
            cfg_wbyte[b] = pcicfg_pkg::cfg_reset_byte({clear_row_ff, 3'(b)});
         end else begin
            cfg_addr[b]  = dec.cfg_row + pcicfg_pkg::CFG_ROW_W'(3'(b) < dec.lane);
            cfg_wbyte[b] = dec.wbytes[b];
         end
         cfg_we[b]   = clear_active_ff | (cfg_wr & dec.be[b]);
         win_addr[b] = dec.win_row + pcicfg_pkg::WIN_ROW_W'(3'(b) < dec.lane);
         win_we[b]   = win_wr & dec.be[b];
      end
   end

   // track BAR0 bytes in a shadow so window decode needs no config read
   always_comb begin
      bar_in = bar_ff;
      for (int b = 0; b < L; b++) begin
         if (cfg_wr && dec.be[b]
             && cfg_addr[b] == pcicfg_pkg::CFG_ROW_W'(pcicfg_pkg::BAR0_ROW)) begin
            bar_in[8*b +: 8] = dec.wbytes[b];
         end
      end
   end

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_row_in    = clear_row_ff;
      if (clear_active_ff) begin
         clear_row_in = clear_row_ff + pcicfg_pkg::CFG_ROW_W'(1);
         if (clear_row_ff == pcicfg_pkg::CFG_ROW_W'(pcicfg_pkg::CFG_ROWS - 1)) begin
            clear_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_row_ff    <= '0;
         bar_ff          <= pcicfg_pkg::BAR0_RESET;
         strobe_ff       <= 1'b0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_row_ff    <= clear_row_in;
         bar_ff          <= bar_in;
         strobe_ff       <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff   <= req_tag;
         op_ff    <= req_op;
         space_ff <= req_space;
         hit_ff   <= dec.hit;
         lane_ff  <= dec.lane;
         count_ff <= req_byte_count;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < L; b++) begin
         if (cfg_we[b]) begin
            cfg_mem[b][cfg_addr[b]] <= cfg_wbyte[b];
         end
         if (accept) begin
            cfg_rdata_ff[b] <= cfg_mem[b][cfg_addr[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < L; b++) begin
         if (win_we[b]) begin
            win_mem[b][win_addr[b]] <= dec.wbytes[b];
         end
         if (accept) begin
            win_rdata_ff[b] <= win_mem[b][win_addr[b]];
         end
      end
   end

   // rotate banks back to byte order, then apply miss fill and size mask
   always_comb begin
      for (int i = 0; i < L; i++) begin
         rsrc[i] = 3'(i) + lane_ff;
         if (space_ff == pcicfg_pkg::SPACE_MEM) begin
            rsp_read_data[8*i +: 8] = win_rdata_ff[rsrc[i]];
         end else begin
            rsp_read_data[8*i +: 8] = cfg_rdata_ff[rsrc[i]];
         end
         if (!hit_ff) begin
            rsp_read_data[8*i +: 8] = 8'hFF;
         end
         if (!(count_ff > 4'(i)) || op_ff == pcicfg_pkg::OP_WRITE) begin
            rsp_read_data[8*i +: 8] = 8'h00;
         end
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_reply_tag = tag_ff;

endmodule

### rtl/pcicfg_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI endpoint responder access decode
// Hit checks for config and BAR0 window, bank rows, lane enables and
// rotated write bytes.
// ----------------------------------------------------------------------------
module pcicfg_decode (
   input  logic                 req_op,
   input  logic                 req_space,
   input  logic [4:0]           req_device_number,
   input  logic [2:0]           req_function_number,
   input  logic [63:0]          req_address,
   input  logic [3:0]           req_byte_count,
   input  logic [63:0]          req_write_data,
   input  logic [63:0]          bar_base,
   output pcicfg_pkg::dec_type  dec
);

   logic [63:0]                       base;
   logic [63:0]                       off;
   logic [63:0]                       data;
   logic [pcicfg_pkg::CFG_ADDR_W:0]   cfg_end;
   logic [pcicfg_pkg::WIN_ADDR_W:0]   win_end;
   logic                              cfg_hit;
   logic                              win_hit;
   logic [2:0]                        src [pcicfg_pkg::LANES];

   always_comb begin
      base    = {bar_base[63:4], 4'h0};
      off     = req_address - base;
      cfg_end = {1'b0, req_address[pcicfg_pkg::CFG_ADDR_W-1:0]}
              + (pcicfg_pkg::CFG_ADDR_W+1)'(req_byte_count);
      win_end = {1'b0, off[pcicfg_pkg::WIN_ADDR_W-1:0]}
              + (pcicfg_pkg::WIN_ADDR_W+1)'(req_byte_count);

      cfg_hit = (req_device_number == 5'd0) && (req_function_number == 3'd0)
             && (req_byte_count <= pcicfg_pkg::CFG_MAX_BYTES)
             && (req_address[63:pcicfg_pkg::CFG_ADDR_W] == '0)
             && (cfg_end <= (pcicfg_pkg::CFG_ADDR_W+1)'(pcicfg_pkg::CFG_BYTES));
      win_hit = (req_byte_count <= pcicfg_pkg::WIN_MAX_BYTES)
             && (req_address >= base)
             && (off[63:pcicfg_pkg::WIN_ADDR_W] == '0)
             && (win_end <= (pcicfg_pkg::WIN_ADDR_W+1)'(pcicfg_pkg::WIN_BYTES));

      // BAR0 sizing: full-word write at the BAR keeps window-aligned bits
      data = req_write_data;
      if (req_op == pcicfg_pkg::OP_WRITE
          && req_space == pcicfg_pkg::SPACE_CFG
          && req_address == 64'(pcicfg_pkg::BAR0_OFFSET)
          && req_byte_count == pcicfg_pkg::BAR0_SIZE) begin
         data = (req_write_data & 64'(pcicfg_pkg::BAR0_KEEP_MASK))
              | 64'(pcicfg_pkg::BAR0_FLAGS);
      end

      dec.hit     = (req_space == pcicfg_pkg::SPACE_MEM) ? win_hit : cfg_hit;
      dec.lane    = req_address[2:0];
      dec.cfg_row = req_address[pcicfg_pkg::CFG_ADDR_W-1:3];
      dec.win_row = off[pcicfg_pkg::WIN_ADDR_W-1:3];
      for (int b = 0; b < pcicfg_pkg::LANES; b++) begin
         src[b]        = 3'(b) - req_address[2:0];
         dec.be[b]     = req_byte_count > 4'(src[b]);
         dec.wbytes[b] = data[8*src[b] +: 8];
      end
   end

endmodule
